>>> rtl/bbe_pkg.sv
// Shared types and constants for the B-spline basis evaluator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package bbe_pkg;

    localparam int VAL_W  = 17;
    localparam int KIDX_W = 6;
    localparam int SPAN_W = 6;
    localparam int BIDX_W = 3;
    localparam int DEG_W  = 3;
    localparam int NCP_W  = 6;
    localparam int CNT_W  = 4;
    localparam int POS_W  = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam int DEF_MAX_KNOTS  = 64;
    localparam int DEF_MAX_DEGREE = 7;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [DEG_W-1:0] DEGREE_RST = 3'd3;
    localparam logic [NCP_W-1:0] NCP_RST    = 6'd4;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_NCP    = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic              op;
        logic [KIDX_W-1:0] knot_index;
        logic [VAL_W-1:0]  knot_value;
        logic [VAL_W-1:0]  param_u;
    } item_t;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [NCP_W-1:0] num_ctrl_points;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HI_RD,
        ST_HI_CHK,
        ST_LO_RD,
        ST_LO_CHK,
        ST_SRCH,
        ST_MID_RD,
        ST_MID1_RD,
        ST_MID_CHK,
        ST_BASIS,
        ST_JL_RD,
        ST_JR_RD,
        ST_JR_CAP,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/bbe_regs.sv
// Configuration registers behind the APB-style port.
// Depends on bbe_pkg.
`timescale 1ns / 1ps
module bbe_regs
    import bbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [DEG_W-1:0] degree_reg;
    logic [NCP_W-1:0] ncp_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEGREE_RST;
            ncp_reg    <= NCP_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_DEGREE)
                degree_reg <= pwdata[DEG_W-1:0];
            else
                ncp_reg <= pwdata[NCP_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_DEGREE)
            prdata = {{(APB_DW-DEG_W){1'b0}}, degree_reg};
        else
            prdata = {{(APB_DW-NCP_W){1'b0}}, ncp_reg};
    end

    assign cfg.degree          = degree_reg;
    assign cfg.num_ctrl_points = ncp_reg;

endmodule

>>> rtl/bbe_front.sv
// Front end: takes command words and holds them in a two-entry queue.
// Depends on bbe_pkg.
`timescale 1ns / 1ps
module bbe_front
    import bbe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t item_in,
    output logic  busy,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t       slot_reg [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

>>> rtl/bbe_back.sv
// Back end: knot store, span search and Cox-de Boor recurrence sequencer
// with a shared restoring divider and a split multiplier. Depends on bbe_pkg.
`timescale 1ns / 1ps
module bbe_back
    import bbe_pkg::*;
#(
    parameter int MAX_KNOTS  = DEF_MAX_KNOTS,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              result_valid,
    output logic [SPAN_W-1:0] span,
    output logic [BIDX_W-1:0] basis_index,
    output logic [VAL_W-1:0]  basis_value,
    output logic              last
);

    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int AW    = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1);
    localparam int NUM_W = VAL_W + FRAC_BITS;
    localparam int DEN_W = VAL_W + 1;
    localparam int HALF  = (NUM_W + 1) / 2;
    localparam int PRD_W = VAL_W + HALF;
    localparam int ACC_W = VAL_W + 2 * HALF;
    localparam int DCN_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] ONE_SAT =
        (FRAC_BITS >= VAL_W) ? VAL_MAX : VAL_W'(ONE_Q);

    state_t state_reg, state_next;

    // knot store
    logic [VAL_W-1:0] knot_mem [0:MAX_KNOTS-1];
    logic [VAL_W-1:0] knot_q_reg;
    logic             oob_reg;
    logic signed [POS_W-1:0] rd_pos;
    logic             rd_in_range;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [VAL_W-1:0] knot_v;

    // evaluation context
    logic [VAL_W-1:0]        u_reg;
    logic [CNT_W-1:0]        p_reg;
    logic signed [POS_W-1:0] nc_reg, lo_reg, hi_reg, mid_reg, span_reg;
    logic [VAL_W-1:0]        km_reg;
    logic [CNT_W-1:0]        j_reg, r_reg, e_reg;
    logic [VAL_W-1:0]        saved_reg;
    logic [VAL_W-1:0]        bw_reg [0:MAX_DEGREE];
    logic [VAL_W-1:0]        ld_reg [0:MAX_DEGREE];
    logic [VAL_W-1:0]        rd_reg [0:MAX_DEGREE];

    // arithmetic
    logic [VAL_W-1:0]  rdv_reg, ldv_reg;
    logic [DEN_W-1:0]  den_reg, den_c;
    logic [NUM_W-1:0]  dq_reg, dq_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [DCN_W-1:0]  dcnt_reg;
    logic [2:0]        mcnt_reg;
    logic [PRD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  racc_reg, lacc_reg;
    logic [VAL_W-1:0]  mul_a;
    logic [HALF-1:0]   mul_b, q_lo, q_hi;
    logic [ACC_W:0]    bw_sum;
    logic [ACC_W-1:0]  l_term;
    logic [VAL_W-1:0]  bw_new, saved_new;

    // search helpers
    logic [CNT_W-1:0]        p_eff;
    logic [NCP_W-1:0]        nc_eff;
    logic signed [POS_W:0]   window;
    logic signed [POS_W:0]   mid_lo_sum, mid_hi_sum, init_sum;
    logic                    hi_hit, lo_hit, u_below, u_above;
    logic [CNT_W-1:0]        bw_rd_idx;
    logic [VAL_W-1:0]        bw_rd;

    assign knot_v = oob_reg ? '0 : knot_q_reg;

    assign p_eff  = (CNT_W'(cfg.degree) > CNT_W'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
                                                              : CNT_W'(cfg.degree);
    assign nc_eff = (cfg.num_ctrl_points < NCP_W'(2)) ? NCP_W'(2) : cfg.num_ctrl_points;

    assign hi_hit  = (u_reg >= knot_v);
    assign lo_hit  = (u_reg <= knot_v);
    assign u_below = (u_reg < km_reg);
    assign u_above = (u_reg >= knot_v);

    assign window     = (POS_W+1)'(hi_reg) - (POS_W+1)'(lo_reg);
    assign mid_lo_sum = (POS_W+1)'(lo_reg) + (POS_W+1)'(mid_reg);
    assign mid_hi_sum = (POS_W+1)'(mid_reg) + (POS_W+1)'(hi_reg);
    assign init_sum   = $signed((POS_W+1)'(p_reg)) + (POS_W+1)'(nc_reg);

    assign den_c = DEN_W'(rd_reg[AW'(r_reg + CNT_W'(1))]) + DEN_W'(ld_reg[AW'(j_reg - r_reg)]);

    assign bw_rd_idx = (state_reg == ST_EMIT) ? e_reg : r_reg;
    assign bw_rd     = bw_reg[AW'(bw_rd_idx)];

    // divider step
    assign rem_sh   = {rem_reg, dq_reg[NUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_next = rem_ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
    assign dq_next  = {dq_reg[NUM_W-2:0], rem_ge};

    // multiplier operands: right term low/high, then left term low/high
    assign q_lo  = dq_reg[HALF-1:0];
    assign q_hi  = HALF'(dq_reg >> HALF);
    assign mul_a = mcnt_reg[1] ? ldv_reg : rdv_reg;
    assign mul_b = mcnt_reg[0] ? q_hi : q_lo;

    assign bw_sum    = (ACC_W+1)'(racc_reg >> FRAC_BITS) + (ACC_W+1)'(saved_reg);
    assign bw_new    = (bw_sum > (ACC_W+1)'(VAL_MAX)) ? VAL_MAX : VAL_W'(bw_sum);
    assign l_term    = lacc_reg >> FRAC_BITS;
    assign saved_new = (l_term > ACC_W'(VAL_MAX)) ? VAL_MAX : VAL_W'(l_term);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && q_item.op == OP_EVAL)
                    state_next = ST_HI_RD;
            ST_HI_RD:   state_next = ST_HI_CHK;
            ST_HI_CHK:  state_next = hi_hit ? ST_BASIS : ST_LO_RD;
            ST_LO_RD:   state_next = ST_LO_CHK;
            ST_LO_CHK:  state_next = lo_hit ? ST_BASIS : ST_SRCH;
            ST_SRCH:    state_next = (window > 1) ? ST_MID_RD : ST_BASIS;
            ST_MID_RD:  state_next = ST_MID1_RD;
            ST_MID1_RD: state_next = ST_MID_CHK;
            ST_MID_CHK: state_next = (u_below || u_above) ? ST_SRCH : ST_BASIS;
            ST_BASIS:   state_next = (p_reg == '0) ? ST_EMIT : ST_JL_RD;
            ST_JL_RD:   state_next = ST_JR_RD;
            ST_JR_RD:   state_next = ST_JR_CAP;
            ST_JR_CAP:  state_next = ST_PREP;
            ST_PREP:    state_next = (den_c == '0) ? ST_MUL : ST_DIV;
            ST_DIV:
                if (dcnt_reg == DCN_W'(NUM_W - 1))
                    state_next = ST_MUL;
            ST_MUL:
                if (mcnt_reg == 3'd4)
                    state_next = ST_UPD;
            ST_UPD:
                if (r_reg + CNT_W'(1) == j_reg)
                    state_next = (j_reg == p_reg) ? ST_EMIT : ST_JL_RD;
                else
                    state_next = ST_PREP;
            ST_EMIT:
                if (e_reg == p_reg)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs: queue pop, knot store access
    always_comb
    begin
        q_pop  = 1'b0;
        wr_en  = 1'b0;
        rd_pos = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                wr_en = q_valid && (q_item.op == OP_LOAD) &&
                        ({{(32-KIDX_W){1'b0}}, q_item.knot_index} < 32'(MAX_KNOTS));
            end
            ST_HI_RD:   rd_pos = nc_reg;
            ST_LO_RD:   rd_pos = $signed(POS_W'(p_reg));
            ST_MID_RD:  rd_pos = mid_reg;
            ST_MID1_RD: rd_pos = mid_reg + POS_W'(1);
            ST_JL_RD:   rd_pos = span_reg + POS_W'(1) - $signed(POS_W'(j_reg));
            ST_JR_RD:   rd_pos = span_reg + $signed(POS_W'(j_reg));
            default:    rd_pos = '0;
        endcase
    end

    assign rd_in_range = (rd_pos >= 0) && (32'(rd_pos) < 32'(MAX_KNOTS));
    assign rd_addr     = rd_in_range ? IDX_W'($unsigned(rd_pos)) : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            knot_mem[IDX_W'(q_item.knot_index)] <= q_item.knot_value;
        knot_q_reg <= knot_mem[rd_addr];
        oob_reg    <= !rd_in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == ST_EMIT);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                u_reg  <= q_item.param_u;
                p_reg  <= p_eff;
                nc_reg <= $signed(POS_W'(nc_eff));
            end
            ST_HI_CHK:
                span_reg <= nc_reg - POS_W'(1);
            ST_LO_CHK:
            begin
                span_reg <= $signed(POS_W'(p_reg));
                lo_reg   <= $signed(POS_W'(p_reg));
                hi_reg   <= nc_reg;
                mid_reg  <= POS_W'(init_sum >>> 1);
            end
            ST_SRCH:
                span_reg <= mid_reg;
            ST_MID1_RD:
                km_reg <= knot_v;
            ST_MID_CHK:
            begin
                span_reg <= mid_reg;
                if (u_below)
                begin
                    hi_reg  <= mid_reg;
                    mid_reg <= POS_W'(mid_lo_sum >>> 1);
                end
                else if (u_above)
                begin
                    lo_reg  <= mid_reg;
                    mid_reg <= POS_W'(mid_hi_sum >>> 1);
                end
            end
            ST_BASIS:
            begin
                bw_reg[0] <= ONE_SAT;
                j_reg     <= CNT_W'(1);
                e_reg     <= '0;
            end
            ST_JR_RD:
                ld_reg[AW'(j_reg)] <= (u_reg > knot_v) ? u_reg - knot_v : '0;
            ST_JR_CAP:
            begin
                rd_reg[AW'(j_reg)] <= (knot_v > u_reg) ? knot_v - u_reg : '0;
                r_reg     <= '0;
                saved_reg <= '0;
            end
            ST_PREP:
            begin
                rdv_reg  <= rd_reg[AW'(r_reg + CNT_W'(1))];
                ldv_reg  <= ld_reg[AW'(j_reg - r_reg)];
                den_reg  <= den_c;
                rem_reg  <= '0;
                dcnt_reg <= '0;
                mcnt_reg <= '0;
                // zero denominator: quotient is one
                dq_reg   <= (den_c == '0) ? ONE_Q : (NUM_W'(bw_rd) << FRAC_BITS);
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                dq_reg   <= dq_next;
                dcnt_reg <= dcnt_reg + DCN_W'(1);
            end
            ST_MUL:
            begin
                mcnt_reg <= mcnt_reg + 3'd1;
                prod_reg <= mul_a * mul_b;
                unique case (mcnt_reg)
                    3'd1:    racc_reg <= ACC_W'(prod_reg);
                    3'd2:    racc_reg <= racc_reg + (ACC_W'(prod_reg) << HALF);
                    3'd3:    lacc_reg <= ACC_W'(prod_reg);
                    3'd4:    lacc_reg <= lacc_reg + (ACC_W'(prod_reg) << HALF);
                    default: ;
                endcase
            end
            ST_UPD:
            begin
                bw_reg[AW'(r_reg)] <= bw_new;
                if (r_reg + CNT_W'(1) == j_reg)
                begin
                    bw_reg[AW'(j_reg)] <= saved_new;
                    j_reg <= j_reg + CNT_W'(1);
                end
                else
                begin
                    r_reg     <= r_reg + CNT_W'(1);
                    saved_reg <= saved_new;
                end
            end
            ST_EMIT:
            begin
                span        <= SPAN_W'($unsigned(span_reg));
                basis_index <= BIDX_W'(e_reg);
                basis_value <= bw_rd;
                last        <= (e_reg == p_reg);
                e_reg       <= e_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/bspline_basis_eval.sv
// B-spline span finder and basis evaluator, top level.
// Load word: written to the knot store once popped. Evaluate word: popped, then a span
// search (end knots, then bisection), two knot reads per row and p*(p+1)/2 steps, each
// with a divide of NUM_W = 17+FRAC_BITS bits (none on a zero denominator), then p+1 results.
// Up to two words queue while one is at work. Results cannot be stalled.
// Reset is asynchronous, active low; the knot store is not cleared.
`timescale 1ns / 1ps
module bspline_basis_eval
    import bbe_pkg::*;
#(
    parameter int MAX_KNOTS  = DEF_MAX_KNOTS,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [KIDX_W-1:0] knot_index,
    input  logic [VAL_W-1:0]  knot_value,
    input  logic [VAL_W-1:0]  param_u,
    output logic              result_valid,
    output logic [SPAN_W-1:0] span,
    output logic [BIDX_W-1:0] basis_index,
    output logic [VAL_W-1:0]  basis_value,
    output logic              last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    item_t item_in;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign item_in.op         = op;
    assign item_in.knot_index = knot_index;
    assign item_in.knot_value = knot_value;
    assign item_in.param_u    = param_u;

    bbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item_in (item_in),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bbe_back #(
        .MAX_KNOTS  (MAX_KNOTS),
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .span         (span),
        .basis_index  (basis_index),
        .basis_value  (basis_value),
        .last         (last)
    );

endmodule

>>> rtl/bbe_checker.sv
// Port-level checks on the result stream of the basis evaluator.
// Depends on bbe_pkg; bound to bspline_basis_eval.
`timescale 1ns / 1ps
module bbe_checker
    import bbe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic [SPAN_W-1:0] span,
    input logic [BIDX_W-1:0] basis_index,
    input logic              last
);

    // a run ends before the next begins
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result word follows last word of a run");

    // words of a run come back to back in index order
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=>
            result_valid && basis_index == BIDX_W'($past(basis_index) + 3'd1))
        else $error("basis index gap inside a run");

    // one span for the whole run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> $stable(span))
        else $error("span changed inside a run");

    // a run opens at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid) |-> basis_index == '0)
        else $error("run does not start at index zero");

endmodule

bind bspline_basis_eval bbe_checker u_bbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .span         (span),
    .basis_index  (basis_index),
    .last         (last)
);

>>> bench/tb_bspline_basis_eval.sv
// Testbench for bspline_basis_eval: knot loads and basis evaluations checked
// against a fixed-point span search and Cox-de Boor predictor in a scoreboard.
// Depends on rtl/bbe_pkg.sv and rtl/bspline_basis_eval.sv.
`timescale 1ns / 1ps
module tb_bspline_basis_eval;
    import bbe_pkg::*;

    localparam int KNOT_CNT   = 64;
    localparam int DEG_CAP    = 7;
    localparam int ONE_FX     = 65536;
    localparam int WDOG_LIMIT = 6000;
    localparam int RAND_ITEMS = 180;

    typedef struct {
        logic [SPAN_W-1:0] span;
        logic [BIDX_W-1:0] bidx;
        logic [VAL_W-1:0]  value;
        logic              last;
    } basis_word_t;

    class basis_scoreboard;
        longint unsigned knots[KNOT_CNT];
        int unsigned     deg_cfg;
        int unsigned     ncp_cfg;
        basis_word_t     pending[$];
        int              errors;
        int              evals;
        int              words;

        function new();
            foreach (knots[i]) knots[i] = 0;
            deg_cfg = DEGREE_RST;
            ncp_cfg = NCP_RST;
            errors = 0;
            evals = 0;
            words = 0;
        endfunction

        function longint unsigned knot_at(int pos);
            if (pos < 0 || pos >= KNOT_CNT)
                return 0;
            return knots[pos];
        endfunction

        function longint unsigned clip(longint unsigned v);
            return v > VAL_MAX ? VAL_MAX : v;
        endfunction

        function longint unsigned diff_floor(longint unsigned a, longint unsigned b);
            return a > b ? a - b : 0;
        endfunction

        function int find_span(longint unsigned u, int nc, int p);
            int lo, hi, mid;
            if (u >= knot_at(nc))
                return nc - 1;
            if (u <= knot_at(p))
                return p;
            lo = p;
            hi = nc;
            mid = (lo + hi) / 2;
            while (hi - lo > 1 && (u < knot_at(mid) || u >= knot_at(mid + 1))) begin
                if (u < knot_at(mid))
                    hi = mid;
                else
                    lo = mid;
                mid = (lo + hi) / 2;
            end
            return mid;
        endfunction

        function void note_item(logic opc, logic [KIDX_W-1:0] idx,
                                logic [VAL_W-1:0] kv, logic [VAL_W-1:0] u_in);
            longint unsigned bw[DEG_CAP+1];
            longint unsigned lft[DEG_CAP+1];
            longint unsigned rgt[DEG_CAP+1];
            longint unsigned u, saved, den, quot;
            int p, nc, sp;
            basis_word_t w;
            if (opc == OP_LOAD) begin
                knots[idx] = kv;
                return;
            end
            evals++;
            u = u_in;
            p = deg_cfg > DEG_CAP ? DEG_CAP : deg_cfg;
            nc = ncp_cfg < 2 ? 2 : ncp_cfg;
            sp = find_span(u, nc, p);
            foreach (bw[i]) begin
                bw[i] = 0;
                lft[i] = 0;
                rgt[i] = 0;
            end
            bw[0] = ONE_FX;
            for (int j = 1; j <= p; j++) begin
                lft[j] = diff_floor(u, knot_at(sp + 1 - j));
                rgt[j] = diff_floor(knot_at(sp + j), u);
                saved = 0;
                for (int r = 0; r < j; r++) begin
                    den = rgt[r+1] + lft[j-r];
                    quot = (den == 0) ? ONE_FX : (bw[r] << 16) / den;
                    bw[r] = clip(saved + ((rgt[r+1] * quot) >> 16));
                    saved = clip((lft[j-r] * quot) >> 16);
                end
                bw[j] = saved;
            end
            for (int j = 0; j <= p; j++) begin
                w.span = sp;
                w.bidx = j;
                w.value = bw[j];
                w.last = (j == p);
                pending.push_back(w);
            end
        endfunction

        function void check_result(logic [SPAN_W-1:0] sp, logic [BIDX_W-1:0] bi,
                                   logic [VAL_W-1:0] v, logic lst);
            basis_word_t w;
            words++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word span=%0d idx=%0d value=%0d last=%0b",
                         $time, sp, bi, v, lst);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (sp !== w.span) begin
                $display("%0t: span expected %0d actual %0d", $time, w.span, sp);
                errors++;
            end
            if (bi !== w.bidx) begin
                $display("%0t: basis_index expected %0d actual %0d", $time, w.bidx, bi);
                errors++;
            end
            if (v !== w.value) begin
                $display("%0t: basis_value expected %0d actual %0d (idx %0d)",
                         $time, w.value, v, w.bidx);
                errors++;
            end
            if (lst !== w.last) begin
                $display("%0t: last expected %0b actual %0b", $time, w.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              op;
    logic [KIDX_W-1:0] knot_index;
    logic [VAL_W-1:0]  knot_value;
    logic [VAL_W-1:0]  param_u;
    logic              result_valid;
    logic [SPAN_W-1:0] span;
    logic [BIDX_W-1:0] basis_index;
    logic [VAL_W-1:0]  basis_value;
    logic              last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    basis_scoreboard sb;
    int burst_left;
    int idle_cycles;
    int items_sent;

    bspline_basis_eval dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .knot_index(knot_index), .knot_value(knot_value), .param_u(param_u),
        .result_valid(result_valid), .span(span), .basis_index(basis_index),
        .basis_value(basis_value), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Check result words and watch for a stall.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid)
                sb.check_result(span, basis_index, basis_value, last);
            if (result_valid || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout after %0d quiet cycles", idle_cycles);
                $display("bspline_basis_eval test failed");
                $finish;
            end
        end
    end

    task automatic reg_write(logic regsel, int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (regsel == REG_DEGREE)
            sb.deg_cfg = value;
        else
            sb.ncp_cfg = value;
    endtask

    // Drive one word and hold it until the block takes it; gaps come between bursts.
    task automatic send_word(logic opc, int idx, int kv, int u);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        start <= 1'b1;
        op <= opc;
        knot_index <= KIDX_W'(idx);
        knot_value <= VAL_W'(kv);
        param_u <= VAL_W'(u);
        do
            @(posedge clk);
        while (busy);
        sb.note_item(opc, KIDX_W'(idx), VAL_W'(kv), VAL_W'(u));
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // trailing loads may still be in flight
        repeat (40) @(posedge clk);
    endtask

    // Clamped knot vector: degree+1 repeats at each end, interior sorted.
    task automatic load_clamped(int p, int nc, bit uniform);
        int kv;
        int nint;
        nint = nc - p;
        for (int i = 0; i <= nc + p; i++) begin
            if (i <= p)
                kv = 0;
            else if (i >= nc)
                kv = ONE_FX;
            else if (uniform)
                kv = ((i - p) * ONE_FX) / nint;
            else
                kv = $urandom_range(sb.knots[i-1], sb.knots[i-1] + 2 * ONE_FX / nint);
            if (kv > ONE_FX)
                kv = ONE_FX;
            send_word(OP_LOAD, i, kv, 0);
        end
    endtask

    initial
    begin
        int degs[6];
        int ncps[6];
        int per_phase;
        int p;
        int nc;
        int ksel;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD;
        knot_index = '0;
        knot_value = '0;
        param_u = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        burst_left = 0;
        items_sent = 0;
        degs = '{3, 1, 7, 2, 5, 7};
        ncps = '{4, 2, 56, 10, 20, 8};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole store so no unwritten knot is ever read.
        for (int i = 0; i < KNOT_CNT; i++)
            send_word(OP_LOAD, i, (i == KNOT_CNT - 1) ? ONE_FX : (i * 1024), 0);

        // Directed part at reset settings: clamps, exact knots, zero denominators.
        load_clamped(3, 4, 1);
        send_word(OP_EVAL, 0, 0, 0);
        send_word(OP_EVAL, 0, 0, ONE_FX);
        send_word(OP_EVAL, 0, 0, 32768);
        send_word(OP_EVAL, 0, 0, 1);
        send_word(OP_EVAL, 0, 0, 131071);
        send_word(OP_LOAD, 63, ONE_FX, 0);
        send_word(OP_LOAD, 4, 40000, 0);
        send_word(OP_LOAD, 5, 20000, 0);
        send_word(OP_EVAL, 0, 0, 30000);
        send_word(OP_EVAL, 0, 0, 40000);
        drain();

        per_phase = RAND_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            p = degs[ph];
            nc = ncps[ph];
            reg_write(REG_DEGREE, p);
            reg_write(REG_NCP, nc);
            load_clamped(p, nc, ph % 2);
            for (int k = 0; k < per_phase; k++) begin
                ksel = $urandom_range(0, 99);
                if (ksel < 80)
                    send_word(OP_EVAL, $urandom_range(0, 63), $urandom_range(0, 131071),
                              $urandom_range(0, ONE_FX));
                else if (ksel < 88)
                    send_word(OP_EVAL, 0, 0, sb.knots[$urandom_range(p, nc)]);
                else if (ksel < 96)
                    send_word(OP_LOAD, $urandom_range(0, 63), 0, 0);
                else begin
                    // scramble one knot, which can leave the vector unsorted
                    send_word(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, ONE_FX),
                              $urandom_range(0, 131071));
                end
                if (ksel >= 88 && ksel < 96 && $urandom_range(0, 7) == 0)
                    load_clamped(p, nc, 0);
            end
            drain();
        end

        $display("covered %0d words, %0d evaluations, %0d basis words over 6 settings",
                 items_sent, sb.evals, sb.words);
        $display("degree 1..7, control points 2..56, sorted and unsorted knot vectors");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bspline_basis_eval test passed");
        else
            $display("bspline_basis_eval test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bbe_pkg.sv
rtl/bbe_regs.sv
rtl/bbe_front.sv
rtl/bbe_back.sv
rtl/bspline_basis_eval.sv
rtl/bbe_checker.sv
bench/tb_bspline_basis_eval.sv
